/* sv/cmas_pkg.sv */
// ----------------------------------------------------------------------------
// cmas_pkg
// Shared constants for the centered moving average with shrinking edges.
// ----------------------------------------------------------------------------
package cmas_pkg;

  localparam int MAX_HALF_DEF  = 4;
  localparam int POS_WIDTH_DEF = 24;

  // half width register
  localparam int          HW_CFG_W   = 3;
  localparam logic [2:0]  HW_CFG_RST = 3'd4;

  localparam int NUM_AXES = 3;

endpackage

/* sv/centered_moving_average_shrinking_edges.sv */
// ----------------------------------------------------------------------------
// centered_moving_average_shrinking_edges
// Centered moving average of a 3-D position stream, window shrinks at the ends.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_ready    | in_pos_x/y/z, in_final_item
//  result  | out_valid / out_ready  | out_avg_x/y/z, out_end_of_run
//  config  | cfg_we                 | cfg_wdata (half width)
//
//  Each item releases 0 to MAX_HALF+1 results, and each result waits for
//  out_ready. One shared adder does the window sums, the magnitude and
//  rounding steps, the sign restore and a restoring divide that takes one
//  quotient bit a cycle. in_ready is high only when no work is left.
//  Reset is synchronous; history storage needs none.
// ----------------------------------------------------------------------------
module centered_moving_average_shrinking_edges
  import cmas_pkg::*;
#(
  parameter int MAX_HALF  = MAX_HALF_DEF,
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_WIDTH-1:0] in_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_pos_z,
  input  logic                        in_final_item,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [POS_WIDTH-1:0] out_avg_x,
  output logic signed [POS_WIDTH-1:0] out_avg_y,
  output logic signed [POS_WIDTH-1:0] out_avg_z,
  output logic                        out_end_of_run,

  input  logic                        cfg_we,
  input  logic [HW_CFG_W-1:0]         cfg_wdata
);

  localparam int HIST_DEPTH = 2 * MAX_HALF + 1;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int IS_W       = $clog2(HIST_DEPTH + 1);
  localparam int NOP_W      = $clog2(MAX_HALF + 2);
  localparam int HW_W       = $clog2(MAX_HALF + 1);
  localparam int ACC_W      = POS_WIDTH + IDX_W;
  localparam int NUM_W      = ACC_W + 1;
  localparam int ALU_W      = NUM_W + 1;
  localparam int DEN_W      = $clog2(4 * MAX_HALF + 3);
  localparam int REM_W      = DEN_W + 1;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int AX_W       = $clog2(NUM_AXES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ACC,
    S_MAG,
    S_NUM,
    S_DIV,
    S_RES,
    S_EMIT
  } state_t;

  state_t                      state_r;
  logic [HW_CFG_W-1:0]         half_width_r;
  logic signed [POS_WIDTH-1:0] hist_r [NUM_AXES][HIST_DEPTH];
  logic [IS_W-1:0]             items_r;
  logic [NOP_W-1:0]            nop_r;
  logic [HW_W-1:0]             hw_r;
  logic [HW_W-1:0]             h_r;
  logic                        final_r;
  logic [AX_W-1:0]             axis_r;
  logic [IDX_W-1:0]            idx_r;
  logic [IDX_W-1:0]            idx0_r;
  logic [IDX_W-1:0]            cnt_r;
  logic [ALU_W-1:0]            acc_r;
  logic                        neg_r;
  logic [NUM_W-1:0]            num_r;
  logic [DEN_W-1:0]            rem_r;
  logic [DCNT_W-1:0]           dcnt_r;
  logic signed [POS_WIDTH-1:0] avg_r [NUM_AXES];
  logic                        out_valid_r;
  logic                        eor_r;

  // effective half width from the register, saturated
  logic [HW_W-1:0] hw_cfg;
  always_comb begin
    if (32'(half_width_r) > MAX_HALF) begin
      hw_cfg = HW_W'(MAX_HALF);
    end else begin
      hw_cfg = HW_W'(half_width_r);
    end
  end

  // window for the oldest pending result
  logic [IS_W-1:0] nop_e, off_e, bef_e, hw_e, h_e;
  logic            emit_go;
  always_comb begin
    nop_e = IS_W'(nop_r);
    hw_e  = IS_W'(hw_r);
    off_e = nop_e - IS_W'(1);
    if (items_r >= nop_e) begin
      bef_e = items_r - nop_e;
    end else begin
      bef_e = '0;
    end
    h_e = hw_e;
    if (bef_e < h_e) begin
      h_e = bef_e;
    end
    if (off_e < h_e) begin
      h_e = off_e;
    end
    emit_go = (nop_r != '0) && (final_r || (nop_e > hw_e));
  end

  // shared adder
  logic signed [POS_WIDTH-1:0] hist_rd;
  logic [REM_W-1:0]            div_sh;
  logic [REM_W-1:0]            div_d;
  logic [ALU_W-1:0]            alu_a, alu_b, alu_y;
  logic                        alu_cin;
  logic                        div_neg;

  assign hist_rd = hist_r[axis_r][idx_r];
  assign div_sh  = {rem_r, num_r[NUM_W-1]};
  assign div_d   = REM_W'({h_r, 2'b10});

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state_r)
      S_ACC: begin
        alu_a = acc_r;
        alu_b = {{(ALU_W-POS_WIDTH){hist_rd[POS_WIDTH-1]}}, hist_rd};
      end
      S_MAG: begin
        alu_a   = acc_r[ALU_W-1] ? ~acc_r : acc_r;
        alu_cin = acc_r[ALU_W-1];
      end
      S_NUM: begin
        alu_a = {acc_r[ALU_W-2:0], 1'b0};
        alu_b = ALU_W'({h_r, 1'b1});
      end
      S_DIV: begin
        alu_a   = ALU_W'(div_sh);
        alu_b   = ~ALU_W'(div_d);
        alu_cin = 1'b1;
      end
      S_RES: begin
        alu_a   = neg_r ? ~ALU_W'(num_r) : ALU_W'(num_r);
        alu_cin = neg_r;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_y = alu_a + alu_b + ALU_W'(alu_cin);
  end

  assign div_neg = alu_y[ALU_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      half_width_r <= HW_CFG_RST;
      items_r      <= '0;
      nop_r        <= '0;
      final_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      eor_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_width_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
              for (int a = 0; a < NUM_AXES; a++) begin
                hist_r[a][i] <= hist_r[a][i-1];
              end
            end
            hist_r[0][0] <= in_pos_x;
            hist_r[1][0] <= in_pos_y;
            hist_r[2][0] <= in_pos_z;
            if (32'(items_r) < HIST_DEPTH) begin
              items_r <= items_r + IS_W'(1);
            end
            if (32'(nop_r) < MAX_HALF + 1) begin
              nop_r <= nop_r + NOP_W'(1);
            end
            final_r <= in_final_item;
            hw_r    <= hw_cfg;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (emit_go) begin
            h_r     <= HW_W'(h_e);
            idx0_r  <= IDX_W'(off_e - h_e);
            idx_r   <= IDX_W'(off_e - h_e);
            cnt_r   <= IDX_W'(h_e << 1);
            axis_r  <= '0;
            acc_r   <= '0;
            state_r <= S_ACC;
          end else begin
            if (final_r) begin
              items_r <= '0;
              nop_r   <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        S_ACC: begin
          acc_r <= alu_y;
          if (cnt_r == '0) begin
            state_r <= S_MAG;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
            cnt_r <= cnt_r - IDX_W'(1);
          end
        end
        S_MAG: begin
          neg_r   <= acc_r[ALU_W-1];
          acc_r   <= alu_y;
          state_r <= S_NUM;
        end
        S_NUM: begin
          // numerator 2*|sum| + den, divided by 2*den below
          num_r   <= alu_y[NUM_W-1:0];
          rem_r   <= '0;
          dcnt_r  <= DCNT_W'(NUM_W);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= div_neg ? div_sh[DEN_W-1:0] : alu_y[DEN_W-1:0];
          num_r  <= {num_r[NUM_W-2:0], ~div_neg};
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == DCNT_W'(1)) begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          avg_r[axis_r] <= alu_y[POS_WIDTH-1:0];
          if (32'(axis_r) == NUM_AXES - 1) begin
            out_valid_r <= 1'b1;
            eor_r       <= final_r && (nop_r == NOP_W'(1));
            state_r     <= S_EMIT;
          end else begin
            axis_r  <= axis_r + AX_W'(1);
            idx_r   <= idx0_r;
            cnt_r   <= IDX_W'({h_r, 1'b0});
            acc_r   <= '0;
            state_r <= S_ACC;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            nop_r       <= nop_r - NOP_W'(1);
            state_r     <= S_CHECK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_avg_x      = avg_r[0];
  assign out_avg_y      = avg_r[1];
  assign out_avg_z      = avg_r[2];
  assign out_end_of_run = eor_r;

`ifndef SYNTHESIS
  // no result is left waiting once new input is taken
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_nop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nop_r) <= MAX_HALF + 1)
    else $error("pending count out of range");

  // end of a stream clears the counters
  a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !emit_go && final_r) |=> (nop_r == '0 && items_r == '0))
    else $error("stream counters not cleared after final item");

  a_eor_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_run) |-> (final_r && nop_r == NOP_W'(1)))
    else $error("end of run flag on a result that is not the last");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (h_r <= hw_r))
    else $error("window wider than the half width");
`endif

endmodule
